// File: src/rvd_pkg.sv
`timescale 1ns / 1ps

package rvd_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned OpWidth   = 6;
  localparam int unsigned RegWidth  = 5;

  typedef enum logic [OpWidth-1:0] {
    OP_ECALL   = 6'd0,
    OP_EBREAK  = 6'd1,
    OP_ADD     = 6'd2,
    OP_SUB     = 6'd3,
    OP_SLL     = 6'd4,
    OP_SLT     = 6'd5,
    OP_SLTU    = 6'd6,
    OP_XOR     = 6'd7,
    OP_SRL     = 6'd8,
    OP_SRA     = 6'd9,
    OP_OR      = 6'd10,
    OP_AND     = 6'd11,
    OP_SLLI    = 6'd12,
    OP_SRLI    = 6'd13,
    OP_SRAI    = 6'd14,
    OP_BEQ     = 6'd15,
    OP_BNE     = 6'd16,
    OP_BLT     = 6'd17,
    OP_BGE     = 6'd18,
    OP_BLTU    = 6'd19,
    OP_BGEU    = 6'd20,
    OP_JALR    = 6'd21,
    OP_ADDI    = 6'd22,
    OP_SLTI    = 6'd23,
    OP_SLTIU   = 6'd24,
    OP_XORI    = 6'd25,
    OP_ORI     = 6'd26,
    OP_ANDI    = 6'd27,
    OP_LB      = 6'd28,
    OP_LH      = 6'd29,
    OP_LW      = 6'd30,
    OP_LBU     = 6'd31,
    OP_LHU     = 6'd32,
    OP_SB      = 6'd33,
    OP_SH      = 6'd34,
    OP_SW      = 6'd35,
    OP_FENCE   = 6'd36,
    OP_JAL     = 6'd37,
    OP_LUI     = 6'd38,
    OP_AUIPC   = 6'd39,
    OP_ILLEGAL = 6'd40
  } op_t;

  // whole-word matches
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  // masks
  localparam logic [31:0] MASK_F7F3 = 32'hfe00_707f;
  localparam logic [31:0] MASK_F3   = 32'h0000_707f;
  localparam logic [31:0] MASK_B_HI = 32'h7e00_0000;
  localparam logic [31:0] MASK_U    = 32'hffff_f000;

  // funct7 + funct3 + opcode patterns
  localparam logic [31:0] PAT_ADD  = 32'h0000_0033;
  localparam logic [31:0] PAT_SUB  = 32'h4000_0033;
  localparam logic [31:0] PAT_SLL  = 32'h0000_1033;
  localparam logic [31:0] PAT_SLT  = 32'h0000_2033;
  localparam logic [31:0] PAT_SLTU = 32'h0000_3033;
  localparam logic [31:0] PAT_XOR  = 32'h0000_4033;
  localparam logic [31:0] PAT_SRL  = 32'h0000_5033;
  localparam logic [31:0] PAT_SRA  = 32'h4000_5033;
  localparam logic [31:0] PAT_OR   = 32'h0000_6033;
  localparam logic [31:0] PAT_AND  = 32'h0000_7033;
  localparam logic [31:0] PAT_SLLI = 32'h0000_1013;
  localparam logic [31:0] PAT_SRLI = 32'h0000_5013;
  localparam logic [31:0] PAT_SRAI = 32'h4000_5013;

  // funct3 + opcode patterns
  localparam logic [31:0] PAT_BEQ   = 32'h0000_0063;
  localparam logic [31:0] PAT_BNE   = 32'h0000_1063;
  localparam logic [31:0] PAT_BLT   = 32'h0000_4063;
  localparam logic [31:0] PAT_BGE   = 32'h0000_5063;
  localparam logic [31:0] PAT_BLTU  = 32'h0000_6063;
  localparam logic [31:0] PAT_BGEU  = 32'h0000_7063;
  localparam logic [31:0] PAT_JALR  = 32'h0000_0067;
  localparam logic [31:0] PAT_ADDI  = 32'h0000_0013;
  localparam logic [31:0] PAT_SLTI  = 32'h0000_2013;
  localparam logic [31:0] PAT_SLTIU = 32'h0000_3013;
  localparam logic [31:0] PAT_XORI  = 32'h0000_4013;
  localparam logic [31:0] PAT_ORI   = 32'h0000_6013;
  localparam logic [31:0] PAT_ANDI  = 32'h0000_7013;
  localparam logic [31:0] PAT_LB    = 32'h0000_0003;
  localparam logic [31:0] PAT_LH    = 32'h0000_1003;
  localparam logic [31:0] PAT_LW    = 32'h0000_2003;
  localparam logic [31:0] PAT_LBU   = 32'h0000_4003;
  localparam logic [31:0] PAT_LHU   = 32'h0000_5003;
  localparam logic [31:0] PAT_SB    = 32'h0000_0023;
  localparam logic [31:0] PAT_SH    = 32'h0000_1023;
  localparam logic [31:0] PAT_SW    = 32'h0000_2023;
  localparam logic [31:0] PAT_FENCE = 32'h0000_000f;

  // opcode only
  localparam logic [6:0] OPC_JAL   = 7'h6f;
  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;

  typedef struct packed {
    op_t                 operation;
    logic [RegWidth-1:0] dest_reg;
    logic [RegWidth-1:0] src_reg_a;
    logic [RegWidth-1:0] src_reg_b;
    logic signed [WordWidth-1:0] immediate;
  } dec_t;

endpackage

// File: src/rvd_ifs.sv
`timescale 1ns / 1ps

interface rvd_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface rvd_dec_if;
  logic               valid;
  logic               ready;
  logic [5:0]         operation;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_a;
  logic [4:0]         src_reg_b;
  logic signed [31:0] immediate;

  modport source (
    output valid, output operation, output dest_reg, output src_reg_a,
    output src_reg_b, output immediate, input ready
  );
  modport sink (
    input valid, input operation, input dest_reg, input src_reg_a,
    input src_reg_b, input immediate, output ready
  );
endinterface

// File: src/rvd_decode.sv
`timescale 1ns / 1ps

module rvd_decode (
  input  logic [31:0]  word,
  output rvd_pkg::dec_t res
);
  import rvd_pkg::*;

  typedef enum logic [2:0] {
    FMT_NONE  = 3'd0,
    FMT_R     = 3'd1,
    FMT_SHIFT = 3'd2,
    FMT_I     = 3'd3,
    FMT_B     = 3'd4,
    FMT_S     = 3'd5,
    FMT_J     = 3'd6,
    FMT_U     = 3'd7
  } fmt_t;

  op_t         op;
  fmt_t        fmt;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;

  assign rd  = word[11:7];
  assign rs1 = word[19:15];
  assign rs2 = word[24:20];

  assign imm_i = {{21{word[31]}}, word[30:20]};
  assign imm_s = {{21{word[31]}}, word[30:25], word[11:7]};
  assign imm_b = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
  assign imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};

  always_comb begin
    op  = OP_ILLEGAL;
    fmt = FMT_NONE;
    if (word == WORD_ECALL) begin
      op = OP_ECALL;
    end else if (word == WORD_EBREAK) begin
      op = OP_EBREAK;
    end else begin
      case (word & MASK_F7F3)
        PAT_ADD:  begin op = OP_ADD;  fmt = FMT_R; end
        PAT_SUB:  begin op = OP_SUB;  fmt = FMT_R; end
        PAT_SLL:  begin op = OP_SLL;  fmt = FMT_R; end
        PAT_SLT:  begin op = OP_SLT;  fmt = FMT_R; end
        PAT_SLTU: begin op = OP_SLTU; fmt = FMT_R; end
        PAT_XOR:  begin op = OP_XOR;  fmt = FMT_R; end
        PAT_SRL:  begin op = OP_SRL;  fmt = FMT_R; end
        PAT_SRA:  begin op = OP_SRA;  fmt = FMT_R; end
        PAT_OR:   begin op = OP_OR;   fmt = FMT_R; end
        PAT_AND:  begin op = OP_AND;  fmt = FMT_R; end
        PAT_SLLI: begin op = OP_SLLI; fmt = FMT_SHIFT; end
        PAT_SRLI: begin op = OP_SRLI; fmt = FMT_SHIFT; end
        PAT_SRAI: begin op = OP_SRAI; fmt = FMT_SHIFT; end
        default: begin
          case (word & MASK_F3)
            PAT_BEQ:   begin op = OP_BEQ;   fmt = FMT_B; end
            PAT_BNE:   begin op = OP_BNE;   fmt = FMT_B; end
            PAT_BLT:   begin op = OP_BLT;   fmt = FMT_B; end
            PAT_BGE:   begin op = OP_BGE;   fmt = FMT_B; end
            PAT_BLTU:  begin op = OP_BLTU;  fmt = FMT_B; end
            PAT_BGEU:  begin op = OP_BGEU;  fmt = FMT_B; end
            PAT_JALR:  begin op = OP_JALR;  fmt = FMT_I; end
            PAT_ADDI:  begin op = OP_ADDI;  fmt = FMT_I; end
            PAT_SLTI:  begin op = OP_SLTI;  fmt = FMT_I; end
            PAT_SLTIU: begin op = OP_SLTIU; fmt = FMT_I; end
            PAT_XORI:  begin op = OP_XORI;  fmt = FMT_I; end
            PAT_ORI:   begin op = OP_ORI;   fmt = FMT_I; end
            PAT_ANDI:  begin op = OP_ANDI;  fmt = FMT_I; end
            PAT_LB:    begin op = OP_LB;    fmt = FMT_I; end
            PAT_LH:    begin op = OP_LH;    fmt = FMT_I; end
            PAT_LW:    begin op = OP_LW;    fmt = FMT_I; end
            PAT_LBU:   begin op = OP_LBU;   fmt = FMT_I; end
            PAT_LHU:   begin op = OP_LHU;   fmt = FMT_I; end
            PAT_SB:    begin op = OP_SB;    fmt = FMT_S; end
            PAT_SH:    begin op = OP_SH;    fmt = FMT_S; end
            PAT_SW:    begin op = OP_SW;    fmt = FMT_S; end
            PAT_FENCE: begin op = OP_FENCE; fmt = FMT_NONE; end
            default: begin
              case (word[6:0])
                OPC_JAL:   begin op = OP_JAL;   fmt = FMT_J; end
                OPC_LUI:   begin op = OP_LUI;   fmt = FMT_U; end
                OPC_AUIPC: begin op = OP_AUIPC; fmt = FMT_U; end
                default: ;
              endcase
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    res.operation = op;
    res.dest_reg  = '0;
    res.src_reg_a = '0;
    res.src_reg_b = '0;
    res.immediate = '0;
    case (fmt)
      FMT_R: begin
        res.dest_reg  = rd;
        res.src_reg_a = rs1;
        res.src_reg_b = rs2;
      end
      FMT_SHIFT: begin
        res.dest_reg  = rd;
        res.src_reg_a = rs1;
        res.immediate = {27'd0, rs2};
      end
      FMT_I: begin
        res.dest_reg  = rd;
        res.src_reg_a = rs1;
        res.immediate = imm_i;
      end
      FMT_B: begin
        res.src_reg_a = rs1;
        res.src_reg_b = rs2;
        res.immediate = imm_b;
      end
      FMT_S: begin
        res.src_reg_a = rs1;
        res.src_reg_b = rs2;
        res.immediate = imm_s;
      end
      FMT_J: begin
        res.dest_reg  = rd;
        res.immediate = imm_j;
      end
      FMT_U: begin
        res.dest_reg  = rd;
        res.immediate = word & MASK_U;
      end
      default: ;
    endcase
  end

endmodule

// File: src/rv32i_instruction_decoder.sv
`timescale 1ns / 1ps
// rv32i instruction decoder
// instr channel: one raw 32-bit instruction word per request
// dec channel: one decoded request per instruction, in order: operation code,
//   rd, rs1, rs2 and the sign-extended immediate or shift amount; unused
//   fields are zero, anything unrecognized decodes to the illegal code
// path: an accepted instruction is held in the input register, decoded
//   combinationally, then captured in the result register that drives dec
// throughput: one instruction per cycle, sustained while dec is taken
// reset: synchronous; both stages are emptied, no request is pending
// stall: when dec.ready is low the result register holds its request and
//   the input register may still fill; instr.ready drops only once both
//   stages are full, and rises in the same cycle dec is taken
// no configuration and no state beyond the two pipeline registers
module rv32i_instruction_decoder (
  input logic            clk,
  input logic            rst,
  rvd_instr_if.sink      instr,
  rvd_dec_if.source      dec
);
  import rvd_pkg::*;

  logic        in_valid;
  logic [31:0] in_word;
  logic        out_valid;
  dec_t        out_res;
  dec_t        dec_res;
  logic        out_free;
  logic        in_free;

  rvd_decode u_decode (
    .word (in_word),
    .res  (dec_res)
  );

  assign out_free    = !out_valid || dec.ready;
  assign in_free     = !in_valid || out_free;
  assign instr.ready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid <= instr.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && instr.valid) begin
      in_word <= instr.instr_word;
    end
    if (out_free && in_valid) begin
      out_res <= dec_res;
    end
  end

  assign dec.valid     = out_valid;
  assign dec.operation = out_res.operation;
  assign dec.dest_reg  = out_res.dest_reg;
  assign dec.src_reg_a = out_res.src_reg_a;
  assign dec.src_reg_b = out_res.src_reg_b;
  assign dec.immediate = out_res.immediate;

endmodule
